// ----- src/tws_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tws_pkg
// Shared constants, types and helpers of the timed register write sequencer.
// ----------------------------------------------------------------------------
package tws_pkg;

  // Sizes
  localparam int CHANNELS     = 13;
  localparam int SCRIPT_BYTES = 1024;
  localparam int ADDR_W       = $clog2(SCRIPT_BYTES);
  localparam int CH_W         = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // Field widths
  localparam int CMD_W   = 2;
  localparam int CHAN_W  = 4;
  localparam int SADDR_W = 10;
  localparam int BYTE_W  = 8;
  localparam int IO_W    = 16;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd2;

  // I/O register groups
  localparam logic [IO_W-1:0] IO_BASE_A = 16'hFF10;
  localparam logic [IO_W-1:0] IO_BASE_B = 16'hFF16;
  localparam logic [IO_W-1:0] IO_BASE_C = 16'hFF20;
  localparam int GROUP_B_FIRST = 5;
  localparam int GROUP_C_FIRST = 9;

  localparam logic [BYTE_W-1:0] PERIOD_RESET = 8'd4;

  // Request from the sequencer to the output stage
  typedef struct packed {
    logic              push;
    logic              flush;
    logic [CHAN_W-1:0] chan;
    logic [IO_W-1:0]   io;
    logic [BYTE_W-1:0] value;
  } tws_wr_req_t;

  // Status from the output stage back to the sequencer
  typedef struct packed {
    logic ack;
    logic pend_valid;
  } tws_wr_sts_t;

  // Fixed I/O address of a channel
  function automatic logic [IO_W-1:0] io_for(input logic [CH_W-1:0] ch);
    logic [IO_W-1:0] ch16;
    ch16 = IO_W'(ch);
    if (ch16 < IO_W'(GROUP_B_FIRST)) begin
      return IO_BASE_A + ch16;
    end else if (ch16 < IO_W'(GROUP_C_FIRST)) begin
      return IO_BASE_B + ch16 - IO_W'(GROUP_B_FIRST);
    end else begin
      return IO_BASE_C + ch16 - IO_W'(GROUP_C_FIRST);
    end
  endfunction

  // Script pointer advance with wrap
  function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
    if (p == ADDR_W'(SCRIPT_BYTES - 1)) begin
      return '0;
    end else begin
      return p + ADDR_W'(1);
    end
  endfunction

endpackage
`default_nettype wire

// ----- src/tws_if.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tws_in_if / tws_out_if
// Valid/ready channels for commands in and register writes out.
// ----------------------------------------------------------------------------
interface tws_in_if;
  import tws_pkg::*;
  logic               valid;
  logic               ready;
  logic [CMD_W-1:0]   command;
  logic [CHAN_W-1:0]  channel;
  logic [SADDR_W-1:0] script_address;
  logic [BYTE_W-1:0]  script_byte;

  modport source (output valid, command, channel, script_address, script_byte,
                  input ready);
  modport sink   (input valid, command, channel, script_address, script_byte,
                  output ready);
endinterface

interface tws_out_if;
  import tws_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] write_channel;
  logic [IO_W-1:0]   io_address;
  logic [BYTE_W-1:0] write_value;
  logic              last_write;

  modport source (output valid, write_channel, io_address, write_value, last_write,
                  input ready);
  modport sink   (input valid, write_channel, io_address, write_value, last_write,
                  output ready);
endinterface
`default_nettype wire

// ----- src/tws_out_stage.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tws_out_stage
// Holds the newest write back by one so the final write of a command can be
// flagged, and drives the output register.
// ----------------------------------------------------------------------------
module tws_out_stage (
  input  wire                  clk,
  input  wire                  rst_n,
  input  tws_pkg::tws_wr_req_t req,
  output tws_pkg::tws_wr_sts_t sts,
  tws_out_if.source            out_ch
);
  import tws_pkg::*;

  logic              pend_v_r;
  logic [CHAN_W-1:0] pend_chan_r;
  logic [IO_W-1:0]   pend_io_r;
  logic [BYTE_W-1:0] pend_value_r;

  logic              out_valid_r;
  logic [CHAN_W-1:0] out_chan_r;
  logic [IO_W-1:0]   out_io_r;
  logic [BYTE_W-1:0] out_value_r;
  logic              out_last_r;

  logic out_free;
  logic move;
  logic ack;

  // Pending entry moves out when the output register frees up
  assign out_free = !out_valid_r || out_ch.ready;
  assign ack      = (req.push || req.flush) && (!pend_v_r || out_free);
  assign move     = (req.push || req.flush) && pend_v_r && out_free;

  assign sts.ack        = ack;
  assign sts.pend_valid = pend_v_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      // Output register
      if (move) begin
        out_valid_r <= 1'b1;
        out_chan_r  <= pend_chan_r;
        out_io_r    <= pend_io_r;
        out_value_r <= pend_value_r;
        out_last_r  <= req.flush;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      // Pending entry
      if (req.push && ack) begin
        pend_v_r     <= 1'b1;
        pend_chan_r  <= req.chan;
        pend_io_r    <= req.io;
        pend_value_r <= req.value;
      end else if (req.flush && ack) begin
        pend_v_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.write_channel = out_chan_r;
  assign out_ch.io_address    = out_io_r;
  assign out_ch.write_value   = out_value_r;
  assign out_ch.last_write    = out_last_r;

  // Checks
  a_flush_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (req.flush && ack) |=> !pend_v_r) else $error("pending write left after flush");
  a_push_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (req.push && ack) |=> pend_v_r) else $error("pushed write not held");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ch.ready)
      |=> (out_valid_r && $stable(out_value_r) && $stable(out_chan_r)))
    else $error("output transaction changed while stalled");

endmodule
`default_nettype wire

// ----- src/timed_register_write_sequencer_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// timed_register_write_sequencer_top
// Thirteen channels replay (frames, value) scripts from a shared script RAM
// and emit register writes on a prescaled step pass.
// ----------------------------------------------------------------------------
//  Channel   Direction  Carries
//  in_ch     sink       command, channel, script_address, script_byte
//  out_ch    source     write_channel, io_address, write_value, last_write
//  cfg_*     write-only update_period (prescaler reload)
//
//  Load and a tick without a pass complete on acceptance. Start fetches its
//  channel's frame count and value, then flushes, or just flushes if the script
//  ends. Tick with pass: channels in turn, a pair fetch for each one that
//  expires (frames only if it ends), then a flush: single-port RAM, serial channels.
//  Reset clears channels and prescaler; script RAM is not cleared.
//  A stalled out_ch holds the sequencer only when a write must be moved out.
// ----------------------------------------------------------------------------
module timed_register_write_sequencer_top (
  input  wire                         clk,
  input  wire                         rst_n,
  tws_in_if.sink                      in_ch,
  tws_out_if.source                   out_ch,
  input  wire                         cfg_wr_en,
  input  wire [tws_pkg::BYTE_W-1:0]   cfg_wr_data
);
  import tws_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_STEP,
    S_WT_FR,
    S_WT_VAL,
    S_FLUSH
  } state_t;

  state_t             state_r;
  logic [ADDR_W-1:0]  ptr_r    [CHANNELS];
  logic [BYTE_W-1:0]  frames_r [CHANNELS];
  logic [CHANNELS-1:0] active_r;
  logic [CH_W-1:0]    cur_r;
  logic               start_mode_r;
  logic [BYTE_W-1:0]  prescale_r;
  logic [BYTE_W-1:0]  period_r;

  logic [BYTE_W-1:0]  script_mem [SCRIPT_BYTES];
  logic [BYTE_W-1:0]  mem_q_r;

  logic               accept;
  logic               start_ok;
  logic [BYTE_W-1:0]  prescale_dec;
  logic [BYTE_W-1:0]  frames_dec;
  logic               last_ch;
  logic [CH_W-1:0]    in_ch_idx;
  logic [ADDR_W-1:0]  in_addr;
  logic               mem_we;
  logic               mem_re;
  logic [ADDR_W-1:0]  mem_ra;

  tws_wr_req_t        wr_req;
  tws_wr_sts_t        wr_sts;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign accept       = in_ch.valid && in_ch.ready;
  assign start_ok     = (32'(in_ch.channel) < CHANNELS);
  assign in_ch_idx    = CH_W'(in_ch.channel);
  assign in_addr      = ADDR_W'(in_ch.script_address);
  assign prescale_dec = prescale_r - BYTE_W'(1);
  assign frames_dec   = frames_r[cur_r] - BYTE_W'(1);
  assign last_ch      = (cur_r == CH_W'(CHANNELS - 1));

  // Script RAM port control
  always_comb begin
    mem_we = accept && (in_ch.command == CMD_LOAD);
    mem_re = 1'b0;
    mem_ra = ptr_r[cur_r];
    case (state_r)
      S_IDLE: begin
        mem_re = accept && (in_ch.command == CMD_START) && start_ok;
        mem_ra = in_addr;
      end
      S_STEP:  mem_re = active_r[cur_r] && (frames_dec == '0);
      S_WT_FR: mem_re = (mem_q_r != '0);
      default: mem_re = 1'b0;
    endcase
  end

  // Script RAM, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      script_mem[in_addr] <= in_ch.script_byte;
    end
    if (mem_re) begin
      mem_q_r <= script_mem[mem_ra];
    end
  end

  // Requests to the output stage
  always_comb begin
    wr_req.push  = (state_r == S_WT_VAL);
    wr_req.flush = (state_r == S_FLUSH);
    wr_req.chan  = CHAN_W'(cur_r);
    wr_req.io    = io_for(cur_r);
    wr_req.value = mem_q_r;
  end

  tws_out_stage u_out (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (wr_req),
    .sts    (wr_sts),
    .out_ch (out_ch)
  );

  // Sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= '0;
      cur_r        <= '0;
      start_mode_r <= 1'b0;
      prescale_r   <= PERIOD_RESET;
      period_r     <= PERIOD_RESET;
      for (int i = 0; i < CHANNELS; i++) begin
        ptr_r[i]    <= '0;
        frames_r[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        period_r <= cfg_wr_data;
      end
      case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_ch.command == CMD_START && start_ok) begin
              cur_r              <= in_ch_idx;
              active_r[in_ch_idx] <= 1'b1;
              ptr_r[in_ch_idx]   <= ptr_inc(in_addr);
              start_mode_r       <= 1'b1;
              state_r            <= S_WT_FR;
            end else if (in_ch.command == CMD_TICK) begin
              if (prescale_dec == '0) begin
                prescale_r   <= period_r;
                cur_r        <= '0;
                start_mode_r <= 1'b0;
                state_r      <= S_STEP;
              end else begin
                prescale_r <= prescale_dec;
              end
            end
          end
        end
        // Count one channel down; fetch on expiry
        S_STEP: begin
          if (active_r[cur_r]) begin
            frames_r[cur_r] <= frames_dec;
          end
          if (active_r[cur_r] && frames_dec == '0) begin
            ptr_r[cur_r] <= ptr_inc(ptr_r[cur_r]);
            state_r      <= S_WT_FR;
          end else if (last_ch) begin
            state_r <= S_FLUSH;
          end else begin
            cur_r <= cur_r + CH_W'(1);
          end
        end
        // Frame count arrives; zero ends the script
        S_WT_FR: begin
          if (mem_q_r == '0) begin
            active_r[cur_r] <= 1'b0;
            if (start_mode_r || last_ch) begin
              state_r <= S_FLUSH;
            end else begin
              cur_r   <= cur_r + CH_W'(1);
              state_r <= S_STEP;
            end
          end else begin
            frames_r[cur_r] <= mem_q_r;
            ptr_r[cur_r]    <= ptr_inc(ptr_r[cur_r]);
            state_r         <= S_WT_VAL;
          end
        end
        // Value arrives; hand the write over
        S_WT_VAL: begin
          if (wr_sts.ack) begin
            if (start_mode_r || last_ch) begin
              state_r <= S_FLUSH;
            end else begin
              cur_r   <= cur_r + CH_W'(1);
              state_r <= S_STEP;
            end
          end
        end
        S_FLUSH: begin
          if (wr_sts.ack) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // Checks
  a_idle_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !wr_sts.pend_valid)
    else $error("pending write left while idle");
  a_frames_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WT_VAL) |-> (frames_r[cur_r] != '0))
    else $error("write emitted with zero frame count");
  a_start_enables: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && in_ch.command == CMD_START && start_ok)
      |=> (state_r == S_WT_FR) && active_r[cur_r])
    else $error("started channel not enabled");

endmodule
`default_nettype wire
